@@ hdl/b32d_pkg.sv @@
// ----------------------------------------------------------------------------
// b32d_pkg
// Shared types and constants for the base32 stream decoder.
// ----------------------------------------------------------------------------
package b32d_pkg;

  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned SYM_W       = 5;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned COUNT_W     = 12;
  localparam int unsigned BUF_W       = 12;
  localparam int unsigned HELD_W      = 3;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int unsigned S_TDATA_W   = 8;
  localparam int unsigned M_TDATA_W   = 24;
  localparam int unsigned PADDR_W     = 3;
  localparam int unsigned PDATA_W     = 32;

  // register index, taken from paddr[2]
  localparam logic REG_MAX_OUTPUT_BYTES = 1'b0;
  localparam logic [COUNT_W-1:0] MAX_OUTPUT_BYTES_RST = 12'd64;

  localparam logic [CHAR_W-1:0] CHAR_NUL     = 8'h00;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [CHAR_W-1:0] CHAR_TWO     = 8'h32;
  localparam logic [CHAR_W-1:0] CHAR_SEVEN   = 8'h37;
  localparam logic [CHAR_W-1:0] DIGIT_BASE   = 8'd26;

  // one classified character on its way to the back end
  typedef struct packed {
    logic             term;
    logic [SYM_W-1:0] sym;
  } item_t;

endpackage

@@ hdl/b32d_front.sv @@
// ----------------------------------------------------------------------------
// b32d_front
// Classifies incoming characters into base32 symbols or the terminator;
// skipped characters are consumed and dropped here.
// ----------------------------------------------------------------------------
module b32d_front (
  input  logic                              s_valid_i,
  output logic                              s_ready_o,
  input  logic [b32d_pkg::CHAR_W-1:0]       char_code_i,
  input  logic                              q_ready_i,
  output logic                              q_push_o,
  output b32d_pkg::item_t                   q_item_o
);

  logic                        is_upper;
  logic                        is_lower;
  logic                        is_digit;
  logic                        is_term;
  logic [b32d_pkg::CHAR_W-1:0] sym_full;

  always_comb begin
    is_upper = (char_code_i >= b32d_pkg::CHAR_UPPER_A) &&
               (char_code_i <= b32d_pkg::CHAR_UPPER_Z);
    is_lower = (char_code_i >= b32d_pkg::CHAR_LOWER_A) &&
               (char_code_i <= b32d_pkg::CHAR_LOWER_Z);
    is_digit = (char_code_i >= b32d_pkg::CHAR_TWO) &&
               (char_code_i <= b32d_pkg::CHAR_SEVEN);
    is_term  = (char_code_i == b32d_pkg::CHAR_NUL);

    priority if (is_upper) begin
      sym_full = char_code_i - b32d_pkg::CHAR_UPPER_A;
    end else if (is_lower) begin
      sym_full = char_code_i - b32d_pkg::CHAR_LOWER_A;
    end else if (is_digit) begin
      sym_full = char_code_i - b32d_pkg::CHAR_TWO + b32d_pkg::DIGIT_BASE;
    end else begin
      sym_full = '0;
    end
  end

  assign s_ready_o     = q_ready_i;
  assign q_push_o      = s_valid_i && q_ready_i && (is_term || is_upper || is_lower || is_digit);
  assign q_item_o.term = is_term;
  assign q_item_o.sym  = sym_full[b32d_pkg::SYM_W-1:0];

endmodule

@@ hdl/b32d_fifo.sv @@
// ----------------------------------------------------------------------------
// b32d_fifo
// Short queue of classified items between front and back end.
// ----------------------------------------------------------------------------
module b32d_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  b32d_pkg::item_t item_i,
  output logic            ready_o,
  output logic            valid_o,
  output b32d_pkg::item_t item_o,
  input  logic            pop_i
);

  b32d_pkg::item_t                 mem_q [b32d_pkg::QUEUE_DEPTH];
  logic [b32d_pkg::QPTR_W-1:0]     wr_ptr_q, wr_ptr_d;
  logic [b32d_pkg::QPTR_W-1:0]     rd_ptr_q, rd_ptr_d;
  logic [b32d_pkg::QCNT_W-1:0]     count_q, count_d;

  assign ready_o = (count_q != b32d_pkg::QCNT_W'(b32d_pkg::QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

@@ hdl/b32d_back.sv @@
// ----------------------------------------------------------------------------
// b32d_back
// Packs symbols into bytes, tracks the byte count and capacity, and holds
// the result beat in an output register.
// ----------------------------------------------------------------------------
module b32d_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [b32d_pkg::COUNT_W-1:0]     max_bytes_i,
  input  logic                             q_valid_i,
  input  b32d_pkg::item_t                  q_item_i,
  output logic                             q_pop_o,
  output logic                             m_valid_o,
  input  logic                             m_ready_i,
  output logic [b32d_pkg::BYTE_W-1:0]      data_byte_o,
  output logic                             is_summary_o,
  output logic [b32d_pkg::COUNT_W-1:0]     byte_count_o,
  output logic                             overflow_o
);

  logic [b32d_pkg::BUF_W-1:0]   buf_q, buf_d;
  logic [b32d_pkg::HELD_W-1:0]  held_q, held_d;
  logic [b32d_pkg::COUNT_W-1:0] cnt_q, cnt_d;
  logic                         ovf_q, ovf_d;

  logic                         out_valid_q, out_valid_d;
  logic [b32d_pkg::BYTE_W-1:0]  out_byte_q, out_byte_d;
  logic                         out_sum_q, out_sum_d;
  logic [b32d_pkg::COUNT_W-1:0] out_cnt_q, out_cnt_d;
  logic                         out_ovf_q, out_ovf_d;

  logic [b32d_pkg::BUF_W-1:0]    buf_shift;
  logic [b32d_pkg::HELD_W:0]     total;
  logic [b32d_pkg::HELD_W-1:0]   rem;
  logic [b32d_pkg::BUF_W-1:0]    byte_wide;
  logic                          emit;

  assign q_pop_o = q_valid_i && (!out_valid_q || m_ready_i);

  always_comb begin
    buf_shift = {buf_q[b32d_pkg::BUF_W-b32d_pkg::SYM_W-1:0], q_item_i.sym};
    total     = {1'b0, held_q} + 4'd5;
    rem       = b32d_pkg::HELD_W'(total - 4'd8);
    byte_wide = buf_shift >> rem;

    buf_d       = buf_q;
    held_d      = held_q;
    cnt_d       = cnt_q;
    ovf_d       = ovf_q;
    emit        = 1'b0;
    out_byte_d  = out_byte_q;
    out_sum_d   = out_sum_q;
    out_cnt_d   = out_cnt_q;
    out_ovf_d   = out_ovf_q;
    out_valid_d = out_valid_q && !m_ready_i;

    if (q_pop_o) begin
      if (q_item_i.term) begin
        emit       = 1'b1;
        out_byte_d = '0;
        out_sum_d  = 1'b1;
        out_cnt_d  = ovf_q ? '0 : cnt_q;
        out_ovf_d  = ovf_q;
        buf_d      = '0;
        held_d     = '0;
        cnt_d      = '0;
        ovf_d      = 1'b0;
      end else if (total < 4'd8) begin
        buf_d  = buf_shift;
        held_d = total[b32d_pkg::HELD_W-1:0];
      end else begin
        // a byte completes; keep only the leftover low bits
        buf_d  = buf_shift & ~({b32d_pkg::BUF_W{1'b1}} << rem);
        held_d = rem;
        if (!ovf_q) begin
          if (cnt_q >= max_bytes_i) begin
            ovf_d = 1'b1;
          end else begin
            cnt_d      = cnt_q + 1'b1;
            emit       = 1'b1;
            out_byte_d = byte_wide[b32d_pkg::BYTE_W-1:0];
            out_sum_d  = 1'b0;
            out_cnt_d  = '0;
            out_ovf_d  = 1'b0;
          end
        end
      end
    end

    if (emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_q       <= '0;
      held_q      <= '0;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      buf_q       <= buf_d;
      held_q      <= held_d;
      cnt_q       <= cnt_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    out_sum_q  <= out_sum_d;
    out_cnt_q  <= out_cnt_d;
    out_ovf_q  <= out_ovf_d;
  end

  assign m_valid_o    = out_valid_q;
  assign data_byte_o  = out_byte_q;
  assign is_summary_o = out_sum_q;
  assign byte_count_o = out_cnt_q;
  assign overflow_o   = out_ovf_q;

  a_ovf_count_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_sum_q && out_ovf_q |-> out_cnt_q == '0)
    else $error("overflow summary with nonzero count");

  a_data_beat_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_sum_q |-> out_cnt_q == '0 && !out_ovf_q)
    else $error("data beat carries summary fields");

  a_term_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o && q_item_i.term |=> held_q == '0 && cnt_q == '0 && !ovf_q && buf_q == '0)
    else $error("string state not cleared after terminator");

  a_bits_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (buf_q >> held_q) == '0)
    else $error("bit buffer holds bits above the held count");

endmodule

@@ hdl/base32_stream_decoder_unit.sv @@
// ----------------------------------------------------------------------------
// base32_stream_decoder_unit
// Streaming base32 decoder: one character per input beat, bytes and an
// end-of-string summary per output beat.
// ----------------------------------------------------------------------------
// A new character is taken every cycle while the output side keeps up; a
// character is written into the queue and, once popped, into the output register.
// The front end classifies each character and drops skipped ones, a
// four-entry queue decouples it from the back end, and the back end packs
// 5-bit symbols into bytes through a single output register, so the
// sustained rate of one character per cycle is set by that register and
// the queue's single push and pop per cycle. A zero character closes the
// string with a summary beat (count, or 0 plus the overflow flag) and
// resets the bit packer. max_output_bytes (address 0, reset 64) caps the
// data beats of a string; it should be written only while the block is idle.
module base32_stream_decoder_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // stream in
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  logic [b32d_pkg::S_TDATA_W-1:0]     s_axis_tdata_i,   // [7:0] char_code
  // stream out
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // [7:0] data_byte, [19:8] byte_count, [20] overflow, [23:21] zero
  output logic [b32d_pkg::M_TDATA_W-1:0]     m_axis_tdata_o,
  output logic                               m_axis_tuser_o,   // [0] is_summary
  // register port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [b32d_pkg::PADDR_W-1:0]       paddr,
  input  logic [b32d_pkg::PDATA_W-1:0]       pwdata,
  output logic [b32d_pkg::PDATA_W-1:0]       prdata,
  output logic                               pready
);

  logic [b32d_pkg::COUNT_W-1:0] max_bytes_q;

  logic            q_push;
  logic            q_ready;
  logic            q_valid;
  logic            q_pop;
  b32d_pkg::item_t q_in;
  b32d_pkg::item_t q_out;

  logic [b32d_pkg::BYTE_W-1:0]  data_byte;
  logic [b32d_pkg::COUNT_W-1:0] byte_count;
  logic                         overflow;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_bytes_q <= b32d_pkg::MAX_OUTPUT_BYTES_RST;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == b32d_pkg::REG_MAX_OUTPUT_BYTES) begin
      max_bytes_q <= pwdata[b32d_pkg::COUNT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == b32d_pkg::REG_MAX_OUTPUT_BYTES) begin
      prdata = {{(b32d_pkg::PDATA_W-b32d_pkg::COUNT_W){1'b0}}, max_bytes_q};
    end
  end

  b32d_front u_front (
    .s_valid_i   (s_axis_tvalid_i),
    .s_ready_o   (s_axis_tready_o),
    .char_code_i (s_axis_tdata_i),
    .q_ready_i   (q_ready),
    .q_push_o    (q_push),
    .q_item_o    (q_in)
  );

  b32d_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_in),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .item_o  (q_out),
    .pop_i   (q_pop)
  );

  b32d_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .max_bytes_i  (max_bytes_q),
    .q_valid_i    (q_valid),
    .q_item_i     (q_out),
    .q_pop_o      (q_pop),
    .m_valid_o    (m_axis_tvalid_o),
    .m_ready_i    (m_axis_tready_i),
    .data_byte_o  (data_byte),
    .is_summary_o (m_axis_tuser_o),
    .byte_count_o (byte_count),
    .overflow_o   (overflow)
  );

  assign m_axis_tdata_o = {3'b000, overflow, byte_count, data_byte};

endmodule
